>>> sv/gal2_pkg.sv
// ----------------------------------------------------------------------------
// gal2_pkg
// Shared types and constants of the gradient accumulator with L2 norm.
// ----------------------------------------------------------------------------
package gal2_pkg;

    // Widths fixed by the item and register formats.
    localparam int VALUE_W  = 16;   // Q4.12 gradient values and scales
    localparam int ENTRY_W  = 32;   // Q20.12 accumulator entries
    localparam int SUM_W    = 64;   // Q40.24 sum of squares
    localparam int NORM_W   = 32;   // Q20.12 norm
    localparam int INDEX_W  = 10;
    localparam int ACTIVE_W = 11;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        CMD_ACCUMULATE = 2'd0,
        CMD_CLEAR      = 2'd1,
        CMD_NORM       = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_IDENTITY_SCALE = 3'd0,
        REG_RESIDUAL_SCALE = 3'd1,
        REG_USE_IDENTITY   = 3'd2,
        REG_USE_RESIDUAL   = 3'd3,
        REG_ACTIVE_ENTRIES = 3'd4
    } t_reg_index;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

endpackage

>>> sv/gal2_isqrt.sv
// ----------------------------------------------------------------------------
// gal2_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gal2_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gal2_pkg::SUM_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [gal2_pkg::NORM_W-1:0] o_root
);
    import gal2_pkg::*;

    localparam logic [SUM_W-1:0] FIRST_BIT = {2'b01, {(SUM_W-2){1'b0}}};
    localparam logic [SUM_W-1:0] LAST_BIT  = {{(SUM_W-1){1'b0}}, 1'b1};

    logic             r_busy;
    logic             r_done;
    logic [SUM_W-1:0] r_x;
    logic [SUM_W-1:0] r_res;
    logic [SUM_W-1:0] r_bit;
    logic [SUM_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_radicand;
                r_res  <= '0;
                r_bit  <= FIRST_BIT;
            end else if (r_busy) begin
                // Restoring step: keep the trial subtraction when it fits.
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[NORM_W-1:0];

endmodule

>>> sv/gradient_accumulate_l2_norm.sv
// ----------------------------------------------------------------------------
// gradient_accumulate_l2_norm
// Store of saturating Q20.12 gradient accumulators with accumulate, clear and
// L2 norm commands, held in one synchronous single-port-read memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  in        request    i_in_valid / o_in_ready       cmd, index, values, flags
//  out       result     o_out_valid / i_out_ready     status, norm_value
//  config    APB write  psel, penable, pwrite, pready five registers, 4 bytes apart
//
//  An accumulate holds the block from acceptance until the next request can be
//  taken: memory read, products, rounding, saturating write-back, result load.
//  A rejected or unknown request goes straight to the result load. A clear
//  makes one memory write per entry. A norm over n live entries makes one
//  memory read per entry, then runs the bit-pair square root unit.
//  After reset the block sweeps zeros through all ENTRIES words and accepts
//  no request until the sweep is done; configuration writes are taken
//  throughout. A request is accepted while an earlier result still waits in
//  the output register; a finished result waits only if that register is
//  still occupied.
// ----------------------------------------------------------------------------
module gradient_accumulate_l2_norm #(
    parameter int ENTRIES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [gal2_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic signed [gal2_pkg::VALUE_W-1:0] i_identity_value,
    input  logic                          i_identity_present,
    input  logic signed [gal2_pkg::VALUE_W-1:0] i_residual_value,
    input  logic                          i_residual_present,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_status,
    output logic [gal2_pkg::NORM_W-1:0]   o_norm_value,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gal2_pkg::ADDR_W-1:0]   paddr,
    input  logic [gal2_pkg::DATA_W-1:0]   pwdata,
    output logic [gal2_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gal2_pkg::*;

    // Address width of the store, and a count width that holds ENTRIES itself
    // as well as every value of the active count register.
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = ($clog2(ENTRIES + 1) > ACTIVE_W + 1) ?
                        $clog2(ENTRIES + 1) : ACTIVE_W + 1;
    localparam logic [CW-1:0] LAST_ENTRY = CW'(ENTRIES - 1);
    localparam logic [CW-1:0] ENTRY_COUNT = CW'(ENTRIES);

    localparam logic signed [ENTRY_W+1:0] ENTRY_MAX = (ENTRY_W+2)'(64'sd2147483647);
    localparam logic signed [ENTRY_W+1:0] ENTRY_MIN = -(ENTRY_W+2)'(64'sd2147483648);

    typedef enum logic [9:0] {
        S_INIT    = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_ACC_MUL = 10'b0000000100,
        S_ACC_ADD = 10'b0000001000,
        S_ACC_WR  = 10'b0000010000,
        S_CLR     = 10'b0000100000,
        S_WALK    = 10'b0001000000,
        S_SQRT    = 10'b0010000000,
        S_DONE    = 10'b0100000000,
        S_SPARE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic signed [VALUE_W-1:0] r_identity_scale;
    logic signed [VALUE_W-1:0] r_residual_scale;
    logic                      r_use_identity;
    logic                      r_use_residual;
    logic [ACTIVE_W-1:0]       r_active_entries;

    // Latched request.
    logic [INDEX_W-1:0]        r_idx;
    logic signed [VALUE_W-1:0] r_ival;
    logic signed [VALUE_W-1:0] r_rval;
    logic                      r_ipres;
    logic                      r_rpres;

    // Accumulate datapath.
    logic signed [ENTRY_W-1:0]   r_old;
    logic signed [2*VALUE_W-1:0] r_prod_i;
    logic signed [2*VALUE_W-1:0] r_prod_r;
    logic signed [ENTRY_W-11:0]  r_delta;
    logic signed [2*VALUE_W+1:0] prod_sum;
    logic signed [ENTRY_W+1:0]   new_sum;
    logic [ENTRY_W-1:0]          sat_entry;

    // Walk and norm datapath.
    logic [CW-1:0]      r_walk;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      live_n;
    logic               walk_issue;
    logic               r_rd_vld;
    logic               r_sq_vld;
    logic [ENTRY_W-1:0] mag;
    logic [SUM_W-1:0]   r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W:0]     sum_ext;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [NORM_W-1:0]  sqrt_root;

    // Result staging and output register.
    logic              r_res_status;
    logic [NORM_W-1:0] r_res_norm;
    logic              r_out_vld;
    logic              r_o_status;
    logic [NORM_W-1:0] r_o_norm;
    logic              out_load;

    // Store ports.
    logic [ENTRY_W-1:0] mem [ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra;
    logic [ENTRY_W-1:0] mem_wd;

    logic in_acc;
    logic acc_ok;
    logic cfg_wr;

    assign in_acc = i_in_valid && o_in_ready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // The active count beyond the store depth means the whole store.
    assign live_n = (CW'(r_active_entries) > ENTRY_COUNT) ? ENTRY_COUNT
                                                          : CW'(r_active_entries);
    assign acc_ok = (CW'(i_entry_index) < live_n) &&
                    (i_identity_present || i_residual_present);

    // Exact Q10.24 sum of the Q8.24 products plus one half, then floor to Q.12 by dropping bits.
    assign prod_sum = (2*VALUE_W+2)'(r_prod_i) + (2*VALUE_W+2)'(r_prod_r)
                    + (2*VALUE_W+2)'(2048);
    assign new_sum  = (ENTRY_W+2)'(r_old) + (ENTRY_W+2)'(r_delta);

    always_comb begin
        if (new_sum > ENTRY_MAX) begin
            sat_entry = ENTRY_MAX[ENTRY_W-1:0];
        end else if (new_sum < ENTRY_MIN) begin
            sat_entry = ENTRY_MIN[ENTRY_W-1:0];
        end else begin
            sat_entry = new_sum[ENTRY_W-1:0];
        end
    end

    // Magnitude of a stored entry; the most negative entry maps to 2^31.
    assign mag     = r_rd_data[ENTRY_W-1] ? (~r_rd_data + 1'b1) : r_rd_data;
    assign sum_ext = {1'b0, r_sum} + {1'b0, r_sq};

    // ------------------------------------------------------------------
    // Sequencer: next state and store port control.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        mem_we     = 1'b0;
        mem_wa     = r_walk[AW-1:0];
        mem_wd     = '0;
        mem_ra     = r_walk[AW-1:0];
        walk_issue = 1'b0;
        sqrt_start = 1'b0;
        unique case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                if (r_walk == LAST_ENTRY) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // The read is issued while the request is taken in.
                mem_ra = AW'(i_entry_index);
                if (in_acc) begin
                    case (t_cmd'(i_cmd))
                        CMD_ACCUMULATE: n_state = acc_ok ? S_ACC_MUL : S_DONE;
                        CMD_CLEAR:      n_state = S_CLR;
                        CMD_NORM:       n_state = S_WALK;
                        default:        n_state = S_DONE;
                    endcase
                end
            end
            S_ACC_MUL: n_state = S_ACC_ADD;
            S_ACC_ADD: n_state = S_ACC_WR;
            S_ACC_WR: begin
                mem_we  = 1'b1;
                mem_wa  = AW'(r_idx);
                mem_wd  = sat_entry;
                n_state = S_DONE;
            end
            S_CLR: begin
                mem_we = 1'b1;
                if (r_walk == LAST_ENTRY) begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                walk_issue = (r_walk < r_n);
                if (!walk_issue && !r_rd_vld && !r_sq_vld) begin
                    sqrt_start = 1'b1;
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    // ------------------------------------------------------------------
    // Accumulator store: one write and one registered read per cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // Control and datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_INIT;
            r_walk           <= '0;
            r_rd_vld         <= 1'b0;
            r_sq_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
            r_identity_scale <= 16'sd4096;
            r_residual_scale <= 16'sd4096;
            r_use_identity   <= 1'b1;
            r_use_residual   <= 1'b1;
            r_active_entries <= 11'd1024;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= walk_issue;
            r_sq_vld <= r_rd_vld;
            r_sq     <= SUM_W'(mag) * SUM_W'(mag);

            if (cfg_wr) begin
                case (t_reg_index'(paddr[4:2]))
                    REG_IDENTITY_SCALE: r_identity_scale <= pwdata[VALUE_W-1:0];
                    REG_RESIDUAL_SCALE: r_residual_scale <= pwdata[VALUE_W-1:0];
                    REG_USE_IDENTITY:   r_use_identity   <= pwdata[0];
                    REG_USE_RESIDUAL:   r_use_residual   <= pwdata[0];
                    REG_ACTIVE_ENTRIES: r_active_entries <= pwdata[ACTIVE_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_INIT, S_CLR: begin
                    r_walk <= (r_walk == LAST_ENTRY) ? '0 : r_walk + 1'b1;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx      <= i_entry_index;
                        r_ival     <= i_identity_value;
                        r_rval     <= i_residual_value;
                        r_ipres    <= i_identity_present;
                        r_rpres    <= i_residual_present;
                        r_walk     <= '0;
                        r_n        <= live_n;
                        r_sum      <= '0;
                        r_res_norm <= '0;
                        case (t_cmd'(i_cmd))
                            CMD_ACCUMULATE: r_res_status <= acc_ok ? STATUS_OK
                                                                   : STATUS_INVALID;
                            CMD_CLEAR:      r_res_status <= STATUS_OK;
                            CMD_NORM:       r_res_status <= STATUS_OK;
                            default:        r_res_status <= STATUS_INVALID;
                        endcase
                    end
                end
                S_ACC_MUL: begin
                    // A path adds only when it is both present and enabled.
                    r_old <= r_rd_data;
                    if (r_ipres && r_use_identity) begin
                        r_prod_i <= r_identity_scale * r_ival;
                    end else begin
                        r_prod_i <= '0;
                    end
                    if (r_rpres && r_use_residual) begin
                        r_prod_r <= r_residual_scale * r_rval;
                    end else begin
                        r_prod_r <= '0;
                    end
                end
                S_ACC_ADD: begin
                    r_delta <= prod_sum[2*VALUE_W+1:12];
                end
                S_WALK: begin
                    if (walk_issue) begin
                        r_walk <= r_walk + 1'b1;
                    end
                    if (r_sq_vld) begin
                        r_sum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                    end
                end
                S_SQRT: begin
                    r_walk <= '0;
                    if (sqrt_done) begin
                        r_res_norm <= sqrt_root;
                    end
                end
                S_ACC_WR, S_DONE, S_SPARE: ;
                default: ;
            endcase

            if (out_load) begin
                r_out_vld  <= 1'b1;
                r_o_status <= r_res_status;
                r_o_norm   <= r_res_norm;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    gal2_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_sum),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // ------------------------------------------------------------------
    // Configuration read-back.
    // ------------------------------------------------------------------
    always_comb begin
        case (t_reg_index'(paddr[4:2]))
            REG_IDENTITY_SCALE: prdata = DATA_W'(r_identity_scale[VALUE_W-1:0]);
            REG_RESIDUAL_SCALE: prdata = DATA_W'(r_residual_scale[VALUE_W-1:0]);
            REG_USE_IDENTITY:   prdata = DATA_W'(r_use_identity);
            REG_USE_RESIDUAL:   prdata = DATA_W'(r_use_residual);
            REG_ACTIVE_ENTRIES: prdata = DATA_W'(r_active_entries);
            default:            prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_status     = r_o_status;
    assign o_norm_value = r_o_norm;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_sqrt_done_in_sqrt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_SQRT))
        else $error("square root finished outside the norm sequence");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_walk <= r_n))
        else $error("norm walk ran past the live count");

    a_square_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld |-> $past(r_rd_vld))
        else $error("square valid without a preceding read");

    a_load_leaves_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == S_IDLE) && r_out_vld)
        else $error("result load did not return to idle");

endmodule
